>>> hw/rtl/scpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpc_pkg
// Shared types, widths and codes of the skin color pixel classifier.
// ----------------------------------------------------------------------------
package scpc_pkg;

   localparam int CHROMA_FRAC_BITS = 16;
   localparam int CHAN_W           = 8;
   localparam int SUM_W            = 10;
   localparam logic [SUM_W-1:0] DARK_LIMIT = SUM_W'(50);

   localparam int MEAN_W           = 16;
   localparam int COEF_W           = 32;
   localparam int COEF_FRAC_BITS   = 24;

   localparam int QUO_W               = CHROMA_FRAC_BITS + 1;
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES =
      (QUO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

   localparam int DIFF_W     = CHROMA_FRAC_BITS + 2;
   localparam int PROD_W     = DIFF_W + COEF_W;
   localparam int INNER_W    = PROD_W + 1;
   localparam int INNER_LO_W = INNER_W / 2;
   localparam int INNER_HI_W = INNER_W - INNER_LO_W;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int MLO_W      = DIFF_W + INNER_LO_W + 1;
   localparam int MHI_W      = DIFF_W + INNER_HI_W;
   localparam int LHS_W      = DIFF_W + INNER_W + 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MEAN_RED   = 3'd0,
      CSR_MEAN_GREEN = 3'd1,
      CSR_COEF_CROSS = 3'd2,
      CSR_COEF_GG    = 3'd3,
      CSR_THRESHOLD  = 3'd4
   } csr_index_type;

   localparam logic [MEAN_W-1:0] MEAN_RED_RESET   = 16'd16384;
   localparam logic [MEAN_W-1:0] MEAN_GREEN_RESET = 16'd16384;
   localparam logic [COEF_W-1:0] COEF_CROSS_RESET = 32'd0;
   localparam logic [COEF_W-1:0] COEF_GG_RESET    = 32'd16777216;
   localparam logic [COEF_W-1:0] THRESHOLD_RESET  = 32'd16777216;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic is_skin;
      logic too_dark;
   } result_type;

   typedef struct packed {
      logic [MEAN_W-1:0]        mean_red;
      logic [MEAN_W-1:0]        mean_green;
      logic signed [COEF_W-1:0] coef_cross;
      logic signed [COEF_W-1:0] coef_gg;
      logic signed [COEF_W-1:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              dark;
      logic [SUM_W-1:0]  sum;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
   } div_in_type;

   typedef struct packed {
      logic             valid;
      logic             dark;
      logic [QUO_W-1:0] chroma_red;
      logic [QUO_W-1:0] chroma_green;
   } div_out_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } eval_out_type;

endpackage
`default_nettype wire

>>> hw/rtl/scpc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpc_divider
// Pipelined restoring divider for both chromaticities, several quotient bits
// per stage, one pixel per cycle.
// ----------------------------------------------------------------------------
module scpc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  scpc_pkg::div_in_type   div_i,
   output scpc_pkg::div_out_type  div_o
);
   import scpc_pkg::*;

   typedef struct packed {
      logic             valid;
      logic             dark;
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] rem_red;
      logic [SUM_W-1:0] rem_green;
      logic [QUO_W-1:0] quo_red;
      logic [QUO_W-1:0] quo_green;
   } dstage_type;

   typedef struct packed {
      logic             q;
      logic [SUM_W-1:0] rem;
   } step_type;

   function automatic step_type div_step(input logic [SUM_W-1:0] rem,
                                         input logic [SUM_W-1:0] sum,
                                         input logic             first);
      logic [SUM_W:0] shifted;
      logic [SUM_W:0] diff;
      step_type       st;
      shifted = first ? {1'b0, rem} : {rem, 1'b0};
      diff    = shifted - {1'b0, sum};
      st.q    = (shifted >= {1'b0, sum});
      st.rem  = st.q ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      return st;
   endfunction

   dstage_type stage_src [DIV_STAGES];
   dstage_type stage_in  [DIV_STAGES];
   dstage_type stage_ff  [DIV_STAGES];

   always_comb begin
      stage_src[0].valid     = div_i.valid;
      stage_src[0].dark      = div_i.dark;
      stage_src[0].sum       = div_i.sum;
      stage_src[0].rem_red   = SUM_W'(div_i.red);
      stage_src[0].rem_green = SUM_W'(div_i.green);
      stage_src[0].quo_red   = '0;
      stage_src[0].quo_green = '0;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s > 0) begin : g_link
         assign stage_src[s] = stage_ff[s-1];
      end

      always_comb begin
         dstage_type cur;
         step_type   st;
         cur = stage_src[s];
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            if (s * DIV_STEPS_PER_STAGE + j < QUO_W) begin
               st = div_step(cur.rem_red, cur.sum, (s * DIV_STEPS_PER_STAGE + j) == 0);
               cur.rem_red = st.rem;
               cur.quo_red = {cur.quo_red[QUO_W-2:0], st.q};
               st = div_step(cur.rem_green, cur.sum, (s * DIV_STEPS_PER_STAGE + j) == 0);
               cur.rem_green = st.rem;
               cur.quo_green = {cur.quo_green[QUO_W-2:0], st.q};
            end
         end
         stage_in[s] = cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign div_o.valid        = stage_ff[DIV_STAGES-1].valid;
   assign div_o.dark         = stage_ff[DIV_STAGES-1].dark;
   assign div_o.chroma_red   = stage_ff[DIV_STAGES-1].quo_red;
   assign div_o.chroma_green = stage_ff[DIV_STAGES-1].quo_green;

endmodule
`default_nettype wire

>>> hw/rtl/scpc_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpc_eval
// Pipelined quadratic form on the chromaticity offsets and the skin decision.
// ----------------------------------------------------------------------------
module scpc_eval (
   input  logic                   clock,
   input  logic                   reset,
   input  scpc_pkg::div_out_type  div_i,
   input  scpc_pkg::cfg_type      cfg,
   output scpc_pkg::eval_out_type eval_o
);
   import scpc_pkg::*;

   typedef struct packed {
      logic                     valid;
      logic                     dark;
      logic signed [DIFF_W-1:0] dr;
      logic signed [DIFF_W-1:0] dg;
   } e1_type;

   typedef struct packed {
      logic                     valid;
      logic                     dark;
      logic signed [DIFF_W-1:0] dr;
      logic signed [PROD_W-1:0] p_gg;
      logic signed [PROD_W-1:0] p_cross;
      logic signed [SQ_W-1:0]   sq;
   } e2_type;

   typedef struct packed {
      logic                      valid;
      logic                      dark;
      logic signed [DIFF_W-1:0]  dr;
      logic signed [INNER_W-1:0] inner;
      logic signed [SQ_W-1:0]    sq;
   } e3_type;

   typedef struct packed {
      logic                    valid;
      logic                    dark;
      logic signed [MLO_W-1:0] m_lo;
      logic signed [MHI_W-1:0] m_hi;
      logic signed [SQ_W-1:0]  sq;
   } e4_type;

   typedef struct packed {
      logic                    valid;
      logic                    dark;
      logic signed [LHS_W-1:0] lhs;
   } e5_type;

   e1_type       e1_in, e1_ff;
   e2_type       e2_in, e2_ff;
   e3_type       e3_in, e3_ff;
   e4_type       e4_in, e4_ff;
   e5_type       e5_in, e5_ff;
   eval_out_type out_in, out_ff;

   logic [MEAN_W+CHROMA_FRAC_BITS-1:0] mean_red_wide;
   logic [MEAN_W+CHROMA_FRAC_BITS-1:0] mean_green_wide;
   logic signed [COEF_W-1:0]           coef_gg;
   logic signed [COEF_W-1:0]           coef_cross;
   logic signed [COEF_W-1:0]           threshold;
   logic signed [LHS_W-1:0]            threshold_sh;

   // align Q0.16 means to the chroma format
   assign mean_red_wide   = {cfg.mean_red, {CHROMA_FRAC_BITS{1'b0}}};
   assign mean_green_wide = {cfg.mean_green, {CHROMA_FRAC_BITS{1'b0}}};
   assign coef_gg         = cfg.coef_gg;
   assign coef_cross      = cfg.coef_cross;
   assign threshold       = cfg.threshold;
   assign threshold_sh    = LHS_W'(threshold) <<< (2 * CHROMA_FRAC_BITS);

   always_comb begin
      e1_in.valid = div_i.valid;
      e1_in.dark  = div_i.dark;
      e1_in.dr    = $signed({1'b0, div_i.chroma_red})
                  - $signed({2'b00, mean_red_wide[MEAN_W+CHROMA_FRAC_BITS-1:MEAN_W]});
      e1_in.dg    = $signed({1'b0, div_i.chroma_green})
                  - $signed({2'b00, mean_green_wide[MEAN_W+CHROMA_FRAC_BITS-1:MEAN_W]});

      e2_in.valid   = e1_ff.valid;
      e2_in.dark    = e1_ff.dark;
      e2_in.dr      = e1_ff.dr;
      e2_in.p_gg    = PROD_W'(e1_ff.dr) * PROD_W'(coef_gg);
      e2_in.p_cross = PROD_W'(e1_ff.dg) * PROD_W'(coef_cross);
      e2_in.sq      = SQ_W'(e1_ff.dg) * SQ_W'(e1_ff.dg);

      e3_in.valid = e2_ff.valid;
      e3_in.dark  = e2_ff.dark;
      e3_in.dr    = e2_ff.dr;
      e3_in.inner = INNER_W'(e2_ff.p_gg) - INNER_W'(e2_ff.p_cross);
      e3_in.sq    = e2_ff.sq;

      e4_in.valid = e3_ff.valid;
      e4_in.dark  = e3_ff.dark;
      e4_in.m_lo  = MLO_W'(e3_ff.dr)
                  * MLO_W'($signed({1'b0, e3_ff.inner[INNER_LO_W-1:0]}));
      e4_in.m_hi  = MHI_W'(e3_ff.dr)
                  * MHI_W'($signed(e3_ff.inner[INNER_W-1:INNER_LO_W]));
      e4_in.sq    = e3_ff.sq;

      e5_in.valid = e4_ff.valid;
      e5_in.dark  = e4_ff.dark;
      e5_in.lhs   = (LHS_W'(e4_ff.m_hi) <<< INNER_LO_W) + LHS_W'(e4_ff.m_lo)
                  + (LHS_W'(e4_ff.sq) <<< COEF_FRAC_BITS);

      out_in.valid         = e5_ff.valid;
      out_in.data.too_dark = e5_ff.dark;
      out_in.data.is_skin  = !e5_ff.dark && (e5_ff.lhs < threshold_sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff.valid  <= 1'b0;
         e2_ff.valid  <= 1'b0;
         e3_ff.valid  <= 1'b0;
         e4_ff.valid  <= 1'b0;
         e5_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         e3_ff  <= e3_in;
         e4_ff  <= e4_in;
         e5_ff  <= e5_in;
         out_ff <= out_in;
      end
   end

   assign eval_o = out_ff;

endmodule
`default_nettype wire

>>> hw/rtl/skin_color_pixel_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skin_color_pixel_classifier
// Gaussian skin model on rg chromaticity: sum, two pipelined divisions,
// offsets from the model means and a wide quadratic form against a threshold.
//
//   channel  ports                           direction  handshake
//   request  start, busy, req_data           in         start && !busy
//   result   rsp_valid, rsp_data             out        one-cycle strobe
//   csr      csr_valid, csr_ready, csr_index in         csr_valid && csr_ready
//            csr_wdata
//
// One request per cycle; each request passes the sum register, the divider
// stages of four quotient bits each and the six evaluation stages in order.
// Synchronous reset clears the valid bits and loads the register defaults.
// busy stays low: results leave as strobes, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module skin_color_pixel_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  scpc_pkg::pixel_type                req_data,
   output logic                               rsp_valid,
   output scpc_pkg::result_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import scpc_pkg::*;

   cfg_type      cfg_in, cfg_ff;
   div_in_type   s0_in, s0_ff;
   div_out_type  div_out;
   eval_out_type eval_out;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MEAN_RED:   cfg_in.mean_red   = csr_wdata[MEAN_W-1:0];
            CSR_MEAN_GREEN: cfg_in.mean_green = csr_wdata[MEAN_W-1:0];
            CSR_COEF_CROSS: cfg_in.coef_cross = csr_wdata[COEF_W-1:0];
            CSR_COEF_GG:    cfg_in.coef_gg    = csr_wdata[COEF_W-1:0];
            CSR_THRESHOLD:  cfg_in.threshold  = csr_wdata[COEF_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s0_in.valid = start && !busy;
      s0_in.sum   = SUM_W'(req_data.red) + SUM_W'(req_data.green)
                  + SUM_W'(req_data.blue);
      s0_in.dark  = (s0_in.sum < DARK_LIMIT);
      s0_in.red   = req_data.red;
      s0_in.green = req_data.green;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_red   <= MEAN_RED_RESET;
         cfg_ff.mean_green <= MEAN_GREEN_RESET;
         cfg_ff.coef_cross <= COEF_CROSS_RESET;
         cfg_ff.coef_gg    <= COEF_GG_RESET;
         cfg_ff.threshold  <= THRESHOLD_RESET;
         s0_ff.valid       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         s0_ff  <= s0_in;
      end
   end

   scpc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .div_i (s0_ff),
      .div_o (div_out)
   );

   scpc_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .div_i  (div_out),
      .cfg    (cfg_ff),
      .eval_o (eval_out)
   );

   assign rsp_valid = eval_out.valid;
   assign rsp_data  = eval_out.data;

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Skin color pixel classifier: pixels go in through the start/busy request
// port and each one is checked against a local model of the rg chromaticity
// Gaussian classifier. The run starts with corner pixels under the register
// defaults. It then reprograms all five registers several times, the extreme
// settings among them, and sends random pixels of every kind, with random
// gaps between them.
// ----------------------------------------------------------------------------
module testbench;
   import scpc_pkg::*;

   localparam int PIPE_LATENCY    = 7 + DIV_STAGES;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PLAN_LEN        = 10;

   typedef enum int {
      SET_MIN,
      SET_MAX,
      SET_CORNERS,
      SET_TYPICAL,
      SET_ANY
   } setting_kind_type;

   localparam setting_kind_type SETTING_PLAN[PLAN_LEN] = '{
      SET_TYPICAL, SET_MIN, SET_MAX, SET_CORNERS, SET_TYPICAL,
      SET_ANY, SET_TYPICAL, SET_CORNERS, SET_TYPICAL, SET_ANY
   };

   class skin_scoreboard;
      cfg_type      regs;
      result_type   expected_results[$];
      int unsigned  error_count;

      function new();
         regs.mean_red   = MEAN_RED_RESET;
         regs.mean_green = MEAN_GREEN_RESET;
         regs.coef_cross = COEF_CROSS_RESET;
         regs.coef_gg    = COEF_GG_RESET;
         regs.threshold  = THRESHOLD_RESET;
         error_count     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_MEAN_RED:   regs.mean_red   = value[MEAN_W-1:0];
            CSR_MEAN_GREEN: regs.mean_green = value[MEAN_W-1:0];
            CSR_COEF_CROSS: regs.coef_cross = value[COEF_W-1:0];
            CSR_COEF_GG:    regs.coef_gg    = value[COEF_W-1:0];
            CSR_THRESHOLD:  regs.threshold  = value[COEF_W-1:0];
            default: ;
         endcase
      endfunction

      // offset of a chromaticity from a Q0.16 mean aligned to the chroma format
      function longint chroma_offset(longint chroma, logic [MEAN_W-1:0] mean);
         longint aligned;
         if (CHROMA_FRAC_BITS >= MEAN_W)
            aligned = longint'(mean) << (CHROMA_FRAC_BITS - MEAN_W);
         else
            aligned = longint'(mean) >> (MEAN_W - CHROMA_FRAC_BITS);
         return chroma - aligned;
      endfunction

      function result_type classify_pixel(pixel_type px);
         longint              total;
         longint              dev_r;
         longint              dev_g;
         longint              inner;
         logic signed [127:0] wide_dev_r;
         logic signed [127:0] wide_dev_g;
         logic signed [127:0] wide_inner;
         logic signed [127:0] wide_thr;
         logic signed [127:0] lhs;
         logic signed [127:0] rhs;
         result_type          res;
         res   = '0;
         total = longint'(px.red) + longint'(px.green) + longint'(px.blue);
         if (total < longint'(DARK_LIMIT)) begin
            res.too_dark = 1'b1;
            return res;
         end
         dev_r = chroma_offset((longint'(px.red) << CHROMA_FRAC_BITS) / total,
                               regs.mean_red);
         dev_g = chroma_offset((longint'(px.green) << CHROMA_FRAC_BITS) / total,
                               regs.mean_green);
         inner = dev_r * longint'(regs.coef_gg) - dev_g * longint'(regs.coef_cross);
         wide_dev_r = dev_r;
         wide_dev_g = dev_g;
         wide_inner = inner;
         wide_thr   = regs.threshold;
         lhs = wide_dev_r * wide_inner + ((wide_dev_g * wide_dev_g) <<< COEF_FRAC_BITS);
         rhs = wide_thr <<< (2 * CHROMA_FRAC_BITS);
         res.is_skin = (lhs < rhs);
         return res;
      endfunction

      function void note_pixel(pixel_type px);
         expected_results.push_back(classify_pixel(px));
      endfunction

      function void check_result(result_type actual);
         result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual is_skin %0b too_dark %0b",
                     $time, actual.is_skin, actual.too_dark);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         if (actual.is_skin !== want.is_skin) begin
            $display("%0t: is_skin mismatch, expected %0b actual %0b",
                     $time, want.is_skin, actual.is_skin);
            error_count++;
         end
         if (actual.too_dark !== want.too_dark) begin
            $display("%0t: too_dark mismatch, expected %0b actual %0b",
                     $time, want.too_dark, actual.too_dark);
            error_count++;
         end
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   pixel_type              req_data  = '0;
   logic                   rsp_valid;
   result_type             rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int unsigned            cycle_count = 0;
   skin_scoreboard         board = new();

   skin_color_pixel_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_data);
   end

   // keep start high across back-to-back requests; drop it only before a gap
   task automatic send_pixel(pixel_type px, int unsigned gap);
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      board.note_pixel(px);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic program_registers(cfg_type s, bit poke_unused);
      logic [CSR_INDEX_W-1:0] idx_list[$];
      logic [CSR_DATA_W-1:0]  val_list[$];
      int unsigned            gap;
      idx_list.push_back(CSR_MEAN_RED);
      val_list.push_back({16'($urandom()), s.mean_red});
      idx_list.push_back(CSR_MEAN_GREEN);
      val_list.push_back({16'($urandom()), s.mean_green});
      if (poke_unused) begin
         for (int i = int'(CSR_THRESHOLD) + 1; i < 2 ** CSR_INDEX_W; i++) begin
            idx_list.push_back(CSR_INDEX_W'(i));
            val_list.push_back($urandom());
         end
      end
      idx_list.push_back(CSR_COEF_CROSS);
      val_list.push_back(s.coef_cross);
      idx_list.push_back(CSR_COEF_GG);
      val_list.push_back(s.coef_gg);
      idx_list.push_back(CSR_THRESHOLD);
      val_list.push_back(s.threshold);
      for (int i = 0; i < idx_list.size(); i++) begin
         gap = $urandom_range(0, 3);
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= val_list[i];
         do @(posedge clock); while (!csr_ready);
         board.write_register(idx_list[i], val_list[i]);
         if (gap > 0 || i == idx_list.size() - 1) begin
            csr_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [COEF_W-1:0] pick_extreme();
      case ($urandom_range(0, 2))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         default: return '0;
      endcase
   endfunction

   function automatic cfg_type make_settings(setting_kind_type kind);
      cfg_type s;
      case (kind)
         SET_MIN: begin
            s.mean_red   = '0;
            s.mean_green = '0;
            s.coef_cross = 32'h8000_0000;
            s.coef_gg    = 32'h8000_0000;
            s.threshold  = 32'h8000_0000;
         end
         SET_MAX: begin
            s.mean_red   = '1;
            s.mean_green = '1;
            s.coef_cross = 32'h7FFF_FFFF;
            s.coef_gg    = 32'h7FFF_FFFF;
            s.threshold  = 32'h7FFF_FFFF;
         end
         SET_CORNERS: begin
            s.mean_red   = $urandom_range(0, 1) ? '1 : '0;
            s.mean_green = $urandom_range(0, 1) ? '1 : '0;
            s.coef_cross = pick_extreme();
            s.coef_gg    = pick_extreme();
            s.threshold  = pick_extreme();
         end
         SET_TYPICAL: begin
            s.mean_red   = MEAN_W'($urandom_range(14000, 30000));
            s.mean_green = MEAN_W'($urandom_range(14000, 24000));
            s.coef_cross = $urandom_range(0, 1 << 26) - (1 << 25);
            s.coef_gg    = $urandom_range(1 << 23, 1 << 26);
            s.threshold  = $urandom_range(0, 1 << 22);
         end
         default: begin
            s.mean_red   = MEAN_W'($urandom());
            s.mean_green = MEAN_W'($urandom());
            s.coef_cross = $urandom();
            s.coef_gg    = $urandom();
            s.threshold  = $urandom();
         end
      endcase
      return s;
   endfunction

   function automatic pixel_type draw_pixel();
      pixel_type   px;
      int unsigned target;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            px.red   = CHAN_W'($urandom());
            px.green = CHAN_W'($urandom());
            px.blue  = CHAN_W'($urandom());
         end
         4, 5, 6: begin
            px.red   = CHAN_W'($urandom_range(90, 255));
            px.green = CHAN_W'((px.red * $urandom_range(50, 80)) / 100);
            px.blue  = CHAN_W'((px.red * $urandom_range(30, 70)) / 100);
         end
         7: begin
            px.red   = CHAN_W'($urandom_range(0, 16));
            px.green = CHAN_W'($urandom_range(0, 16));
            px.blue  = CHAN_W'($urandom_range(0, 16));
         end
         8: begin
            target   = $urandom_range(47, 52);
            px.red   = CHAN_W'($urandom_range(0, target));
            px.green = CHAN_W'($urandom_range(0, target - px.red));
            px.blue  = CHAN_W'(target - px.red - px.green);
         end
         default: begin
            px = '0;
            case ($urandom_range(0, 2))
               0:       px.red   = CHAN_W'($urandom_range(0, 255));
               1:       px.green = CHAN_W'($urandom_range(0, 255));
               default: px.blue  = CHAN_W'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 1))
               px.blue = CHAN_W'($urandom_range(0, 255));
         end
      endcase
      return px;
   endfunction

   pixel_type corner_pixels[20] = '{
      {8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255},
      {8'd255, 8'd0,   8'd0},   {8'd0,   8'd255, 8'd0},
      {8'd0,   8'd0,   8'd255}, {8'd49,  8'd0,   8'd0},
      {8'd50,  8'd0,   8'd0},   {8'd0,   8'd50,  8'd0},
      {8'd16,  8'd17,  8'd16},  {8'd17,  8'd17,  8'd16},
      {8'd0,   8'd25,  8'd25},  {8'd1,   8'd1,   8'd47},
      {8'd200, 8'd140, 8'd100}, {8'd180, 8'd120, 8'd90},
      {8'd128, 8'd64,  8'd32},  {8'd255, 8'd255, 8'd0},
      {8'd0,   8'd255, 8'd255}, {8'd255, 8'd0,   8'd255},
      {8'd85,  8'd85,  8'd85},  {8'd170, 8'd85,  8'd85}
   };

   initial begin
      bit          quiet;
      int unsigned gap;
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_pixels[i])
         send_pixel(corner_pixels[i], $urandom_range(0, 3));
      drain_results();

      for (int p = 0; p < PLAN_LEN; p++) begin
         program_registers(make_settings(SETTING_PLAN[p]), (p % 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 19) == 0)
               quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 10);
            send_pixel(draw_pixel(), gap);
         end
         drain_results();
      end

      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (board.expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, board.expected_results.size());
         board.error_count++;
      end
      if (board.error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/scpc_pkg.sv
hw/rtl/scpc_divider.sv
hw/rtl/scpc_eval.sv
hw/rtl/skin_color_pixel_classifier.sv
dv/testbench.sv
